>>> rtl/height_band_texture_blend_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the height band texture blend
// Clocked, reset-qualified assertion shorthands used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_BAND_TEXTURE_BLEND_MACROS_SVH
`define HEIGHT_BAND_TEXTURE_BLEND_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define HBTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define HBTB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/hbtb_pkg.sv
// ----------------------------------------------------------------------------
// hbtb_pkg
// Types, widths and the band step table of the height band texture blend.
// ----------------------------------------------------------------------------
package hbtb_pkg;

  localparam int H_W     = 16;  // height, unsigned 8.8
  localparam int COL_W   = 24;  // one RGB texel
  localparam int CH      = 3;   // color channels
  localparam int CH_W    = 8;   // bits per channel
  localparam int BND_W   = 18;  // band bound, 8.8 with headroom
  localparam int DIV_W   = 16;  // band half width D
  localparam int NUM_W   = 16;  // weight numerator, never above D
  localparam int PROD_W  = CH_W + NUM_W;
  localparam int CNT_W   = 4;   // slot count, up to eight slots
  localparam int QW      = 8;   // quotient bits, one per divider step
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;

  typedef struct packed {
    logic [BND_W-1:0] lo;
    logic [BND_W-1:0] opt;
    logic [BND_W-1:0] hi;
  } bound_t;

  // Band step floor(255*256/n) for n occupied slots.
  function automatic logic [DIV_W-1:0] step_for(input logic [CNT_W-1:0] n);
    logic [DIV_W-1:0] s;
    case (n)
      4'd1:    s = 16'd65280;
      4'd2:    s = 16'd32640;
      4'd3:    s = 16'd21760;
      4'd4:    s = 16'd16320;
      4'd5:    s = 16'd13056;
      4'd6:    s = 16'd10880;
      4'd7:    s = 16'd9325;
      4'd8:    s = 16'd8160;
      default: s = 16'd0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/hbtb_bands.sv
// ----------------------------------------------------------------------------
// hbtb_bands
// Slot mask register and band bound rebuild on each mask write.
// ----------------------------------------------------------------------------
module hbtb_bands #(
  parameter int SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wen,
  input  logic [SLOTS-1:0]                 cfg_wdata,
  output logic [SLOTS-1:0]                 mask_o,
  output hbtb_pkg::bound_t [SLOTS-1:0]     bound_o,
  output logic [hbtb_pkg::DIV_W-1:0]       div_o
);

  logic [SLOTS-1:0]                 mask_r,  mask_nxt;
  hbtb_pkg::bound_t [SLOTS-1:0]     bound_r, bound_nxt;
  logic [hbtb_pkg::DIV_W-1:0]       div_r,   div_nxt;

  logic [hbtb_pkg::CNT_W-1:0]       cnt;
  logic [hbtb_pkg::CNT_W-1:0]       k;
  logic [hbtb_pkg::DIV_W-1:0]       step;
  logic [hbtb_pkg::DIV_W-1:0]       dv;
  logic [19:0]                      lo_full;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cnt = cnt + hbtb_pkg::CNT_W'(cfg_wdata[i]);
    end
    step = hbtb_pkg::step_for(cnt);
    dv   = (cnt == '0) ? '0 : step - 16'd256;

    k       = '0;
    lo_full = '0;
    for (int i = 0; i < SLOTS; i++) begin
      bound_nxt[i] = '0;
      if (cfg_wdata[i]) begin
        lo_full          = 20'(k) * 20'(step);
        bound_nxt[i].lo  = lo_full[hbtb_pkg::BND_W-1:0];
        bound_nxt[i].opt = lo_full[hbtb_pkg::BND_W-1:0] + hbtb_pkg::BND_W'(dv);
        bound_nxt[i].hi  = bound_nxt[i].opt + hbtb_pkg::BND_W'(dv);
        k = k + 4'd1;
      end
    end

    if (cfg_wen) begin
      mask_nxt = cfg_wdata;
      div_nxt  = dv;
    end else begin
      mask_nxt  = mask_r;
      div_nxt   = div_r;
      bound_nxt = bound_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      div_r   <= '0;
      bound_r <= '0;
    end else begin
      mask_r  <= mask_nxt;
      div_r   <= div_nxt;
      bound_r <= bound_nxt;
    end
  end

  assign mask_o  = mask_r;
  assign bound_o = bound_r;
  assign div_o   = div_r;

endmodule

>>> rtl/hbtb_lane.sv
// ----------------------------------------------------------------------------
// hbtb_lane
// One slot: band weight numerator, then per channel color times weight.
// ----------------------------------------------------------------------------
module hbtb_lane (
  input  logic                                          clk,
  input  logic [hbtb_pkg::H_W-1:0]                      h_i,
  input  logic [hbtb_pkg::COL_W-1:0]                    color_i,
  input  logic                                          present_i,
  input  hbtb_pkg::bound_t                              bound_i,
  output logic [hbtb_pkg::CH-1:0][hbtb_pkg::PROD_W-1:0] prod_o
);

  logic [hbtb_pkg::NUM_W-1:0]                    num_r,  num_nxt;
  logic [hbtb_pkg::COL_W-1:0]                    col_r,  col_nxt;
  logic [hbtb_pkg::CH-1:0][hbtb_pkg::PROD_W-1:0] prod_r, prod_nxt;

  logic [hbtb_pkg::BND_W-1:0] h18;
  logic [hbtb_pkg::BND_W-1:0] diff;
  logic                       hit;

  // Stage A: weight numerator, zero outside the band
  always_comb begin
    h18  = hbtb_pkg::BND_W'(h_i);
    hit  = present_i && (h18 >= bound_i.lo) && (h18 <= bound_i.hi);
    diff = (h18 < bound_i.opt) ? (h18 - bound_i.lo) : (bound_i.hi - h18);
    num_nxt = hit ? diff[hbtb_pkg::NUM_W-1:0] : '0;
    col_nxt = color_i;
  end

  // Stage B: channel 0 is red (bits 23:16), channel 2 is blue
  always_comb begin
    for (int c = 0; c < hbtb_pkg::CH; c++) begin
      prod_nxt[c] = hbtb_pkg::PROD_W'(col_r[hbtb_pkg::CH_W*(hbtb_pkg::CH-1-c) +: hbtb_pkg::CH_W])
                    * hbtb_pkg::PROD_W'(num_r);
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    col_r  <= col_nxt;
    prod_r <= prod_nxt;
  end

  assign prod_o = prod_r;

endmodule

>>> rtl/hbtb_merge.sv
// ----------------------------------------------------------------------------
// hbtb_merge
// Sum of the weighted colors of all lanes, per channel.
// ----------------------------------------------------------------------------
module hbtb_merge #(
  parameter int SLOTS = 4,
  parameter int ACC_W = 26
) (
  input  logic                                                      clk,
  input  logic                                                      rst_n,
  input  logic                                                      valid_i,
  input  logic [SLOTS-1:0][hbtb_pkg::CH-1:0][hbtb_pkg::PROD_W-1:0]  prod_i,
  output logic                                                      valid_o,
  output logic [hbtb_pkg::CH-1:0][ACC_W-1:0]                        acc_o
);

  logic                                   valid_r, valid_nxt;
  logic [hbtb_pkg::CH-1:0][ACC_W-1:0]     acc_r,   acc_nxt;

  always_comb begin
    valid_nxt = valid_i;
    for (int c = 0; c < hbtb_pkg::CH; c++) begin
      acc_nxt[c] = '0;
      for (int i = 0; i < SLOTS; i++) begin
        acc_nxt[c] = acc_nxt[c] + ACC_W'(prod_i[i][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign valid_o = valid_r;
  assign acc_o   = acc_r;

endmodule

>>> rtl/hbtb_div.sv
// ----------------------------------------------------------------------------
// hbtb_div
// Pipelined restoring divide by the band half width, one quotient bit per
// stage, with saturation at 255 and black output when no slot is occupied.
// ----------------------------------------------------------------------------
module hbtb_div #(
  parameter int ACC_W = 26
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           valid_i,
  input  logic [hbtb_pkg::CH-1:0][ACC_W-1:0]             acc_i,
  input  logic [hbtb_pkg::DIV_W-1:0]                     div_i,
  output logic                                           valid_o,
  output logic [hbtb_pkg::CH-1:0][hbtb_pkg::CH_W-1:0]    res_o
);

  localparam int REM_W = ACC_W + 1;
  localparam int ST    = hbtb_pkg::QW;

  logic [REM_W-1:0]       rem_r [ST][hbtb_pkg::CH];
  logic [REM_W-1:0]       rem_nxt [ST][hbtb_pkg::CH];
  logic [hbtb_pkg::QW-1:0] q_r  [ST][hbtb_pkg::CH];
  logic [hbtb_pkg::QW-1:0] q_nxt [ST][hbtb_pkg::CH];
  logic                   sat_r [ST][hbtb_pkg::CH];
  logic                   sat_nxt [ST][hbtb_pkg::CH];
  logic [ST-1:0]          v_r, v_nxt;

  logic [REM_W-1:0]        prev_rem [ST][hbtb_pkg::CH];
  logic [hbtb_pkg::QW-1:0] prev_q   [ST][hbtb_pkg::CH];
  logic                    prev_sat [ST][hbtb_pkg::CH];
  logic [REM_W-1:0]        trial;
  logic [REM_W-1:0]        div_ext;

  always_comb begin
    div_ext = REM_W'(div_i);
    // stage inputs: first stage from the accumulator, the rest shift down
    for (int c = 0; c < hbtb_pkg::CH; c++) begin
      prev_rem[0][c] = REM_W'(acc_i[c]);
      prev_q[0][c]   = '0;
      prev_sat[0][c] = REM_W'(acc_i[c]) >= (div_ext << hbtb_pkg::QW);
    end
    for (int s = 1; s < ST; s++) begin
      for (int c = 0; c < hbtb_pkg::CH; c++) begin
        prev_rem[s][c] = rem_r[s-1][c];
        prev_q[s][c]   = q_r[s-1][c];
        prev_sat[s][c] = sat_r[s-1][c];
      end
    end

    trial = '0;
    for (int s = 0; s < ST; s++) begin
      trial = div_ext << (ST - 1 - s);
      for (int c = 0; c < hbtb_pkg::CH; c++) begin
        sat_nxt[s][c] = prev_sat[s][c];
        if (prev_rem[s][c] >= trial) begin
          rem_nxt[s][c] = prev_rem[s][c] - trial;
          q_nxt[s][c]   = {prev_q[s][c][hbtb_pkg::QW-2:0], 1'b1};
        end else begin
          rem_nxt[s][c] = prev_rem[s][c];
          q_nxt[s][c]   = {prev_q[s][c][hbtb_pkg::QW-2:0], 1'b0};
        end
      end
    end

    v_nxt = {v_r[ST-2:0], valid_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  always_comb begin
    for (int c = 0; c < hbtb_pkg::CH; c++) begin
      if (div_i == '0) begin
        res_o[c] = '0;
      end else if (sat_r[ST-1][c]) begin
        res_o[c] = '1;
      end else begin
        res_o[c] = q_r[ST-1][c];
      end
    end
  end

  assign valid_o = v_r[ST-1];

endmodule

>>> rtl/height_band_texture_blend.sv
// Throughput: one pixel per cycle while in_tready is high; the 8-stage
// divider and the lanes never stall, and a 16-entry result queue with an
// outstanding count sets in_tready.
// Reset (rst_n low at a clock edge) empties the pipeline and queue, clears the
// slot mask to zero and all band bounds, so the output is black until written.
// ----------------------------------------------------------------------------
// height_band_texture_blend
// Height-banded blend of per-slot texel colors into one RGB pixel.
// ----------------------------------------------------------------------------
`include "height_band_texture_blend_macros.svh"

module height_band_texture_blend #(
  parameter int SLOTS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // slot_present_mask
  input  logic                          cfg_wen,
  input  logic [SLOTS-1:0]              cfg_wdata,
  // in_tdata, low bit up: height_in[15:0], color_slot0 .. color_slot(SLOTS-1),
  // 24 bits each
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [16+24*SLOTS-1:0]        in_tdata,
  // out_tdata, low bit up: red_out, green_out, blue_out (8 bits each)
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata
);

  localparam int ACC_W = hbtb_pkg::PROD_W + ((SLOTS > 1) ? $clog2(SLOTS) : 0);
  localparam int OCW   = hbtb_pkg::FIFO_AW + 1;

  // --------------------------------------------------------------------------
  // Band bounds: rebuilt in the cycle a mask write lands
  // --------------------------------------------------------------------------
  logic [SLOTS-1:0]                 mask;
  hbtb_pkg::bound_t [SLOTS-1:0]     bound;
  logic [hbtb_pkg::DIV_W-1:0]       div;

  hbtb_bands #(.SLOTS(SLOTS)) u_bands (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .mask_o    (mask),
    .bound_o   (bound),
    .div_o     (div)
  );

  // --------------------------------------------------------------------------
  // Intake: accept whenever the outstanding count leaves room in the queue,
  // so the pipeline itself never has to stall
  // --------------------------------------------------------------------------
  logic in_acc;
  logic out_acc;

  assign in_acc = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Lanes: one per slot, two stages each (weight, then multiply)
  // --------------------------------------------------------------------------
  logic [SLOTS-1:0][hbtb_pkg::CH-1:0][hbtb_pkg::PROD_W-1:0] lane_prod;
  logic [1:0] lane_v_r, lane_v_nxt;

  for (genvar i = 0; i < SLOTS; i++) begin : g_lane
    hbtb_lane u_lane (
      .clk       (clk),
      .h_i       (in_tdata[hbtb_pkg::H_W-1:0]),
      .color_i   (in_tdata[hbtb_pkg::H_W + hbtb_pkg::COL_W*i +: hbtb_pkg::COL_W]),
      .present_i (mask[i]),
      .bound_i   (bound[i]),
      .prod_o    (lane_prod[i])
    );
  end

  // track which lane stages hold a real request
  assign lane_v_nxt = {lane_v_r[0], in_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_v_r <= '0;
    end else begin
      lane_v_r <= lane_v_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Merge lanes, then divide by the band half width
  // --------------------------------------------------------------------------
  logic                                        mrg_v;
  logic [hbtb_pkg::CH-1:0][ACC_W-1:0]          mrg_acc;
  logic                                        div_v;
  logic [hbtb_pkg::CH-1:0][hbtb_pkg::CH_W-1:0] div_res;

  hbtb_merge #(.SLOTS(SLOTS), .ACC_W(ACC_W)) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (lane_v_r[1]),
    .prod_i  (lane_prod),
    .valid_o (mrg_v),
    .acc_o   (mrg_acc)
  );

  hbtb_div #(.ACC_W(ACC_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (mrg_v),
    .acc_i   (mrg_acc),
    .div_i   (div),
    .valid_o (div_v),
    .res_o   (div_res)
  );

  // --------------------------------------------------------------------------
  // Result queue: holds finished pixels while the consumer stalls
  // --------------------------------------------------------------------------
  logic [23:0]                   fifo_mem_r [hbtb_pkg::FIFO_DEPTH];
  logic [hbtb_pkg::FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [hbtb_pkg::FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [OCW-1:0]                fifo_cnt_r, fifo_cnt_nxt;
  logic [OCW-1:0]                out_cnt_r, out_cnt_nxt;   // accepted, not delivered

  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    wr_ptr_nxt   = div_v   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = out_acc ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fifo_cnt_nxt = fifo_cnt_r + OCW'(div_v) - OCW'(out_acc);
    out_cnt_nxt  = out_cnt_r + OCW'(in_acc) - OCW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      out_cnt_r  <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      fifo_cnt_r <= fifo_cnt_nxt;
      out_cnt_r  <= out_cnt_nxt;
    end
  end

  // pack red lowest
  always_ff @(posedge clk) begin
    if (div_v) begin
      fifo_mem_r[wr_ptr_r] <= {div_res[2], div_res[1], div_res[0]};
    end
  end

  assign in_tready  = (out_cnt_r < OCW'(hbtb_pkg::FIFO_DEPTH));
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = fifo_mem_r[rd_ptr_r];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HBTB_ASSERT(a_queue_within_outstanding, fifo_cnt_r <= out_cnt_r, "queue holds more than outstanding")
  `HBTB_ASSERT(a_outstanding_bounded, out_cnt_r <= OCW'(hbtb_pkg::FIFO_DEPTH), "outstanding count overflow")
  `HBTB_NEVER(a_no_overflow_write, div_v && !out_acc && (fifo_cnt_r == OCW'(hbtb_pkg::FIFO_DEPTH)), "result written into full queue")
  `HBTB_ASSERT(a_write_has_owner, div_v |-> (out_cnt_r > fifo_cnt_r), "result without an outstanding request")

endmodule

>>> test/tb_height_band_texture_blend.sv
// ----------------------------------------------------------------------------
// tb_height_band_texture_blend
// Self-checking bench for the height band texture blend. A queue of pixel
// requests feeds a clocked stream driver, and a behavioral model of the band
// table predicts every blended pixel. Each mask setting runs as its own
// phase, and the mask is rewritten only while the pipeline is empty. Random
// stalls hit both sides, and one long output hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb_height_band_texture_blend;
  import hbtb_pkg::*;

  localparam int NSLOT          = 4;
  localparam int LATENCY        = 12;    // request to result latency of the block
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES    = 300;   // long output hold-off
  localparam int PHASE_ITEMS    = 56;

  // One pixel request, laid out as in_tdata: height lowest, then slot 0 up.
  typedef struct packed {
    logic [NSLOT-1:0][COL_W-1:0] color;
    logic [H_W-1:0]              height;
  } pixel_req_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wen    = 1'b0;
  logic [NSLOT-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  pixel_req_t            in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CH*CH_W-1:0]    out_tdata;

  height_band_texture_blend #(
    .SLOTS(NSLOT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Band table model: mirror of the slot mask and the bounds it implies.
  // --------------------------------------------------------------------------
  logic [NSLOT-1:0] slot_mask_q;
  logic [BND_W-1:0] band_lo_q  [NSLOT];
  logic [BND_W-1:0] band_opt_q [NSLOT];
  logic [BND_W-1:0] band_hi_q  [NSLOT];
  logic [BND_W-1:0] band_div_q;

  // Rebuild the bands: equal steps over the occupied slots, in slot order.
  function automatic void load_bands(input logic [NSLOT-1:0] m);
    int unsigned n;
    int unsigned k;
    int unsigned step;
    int unsigned lo;
    int unsigned op;
    int unsigned hi;
    n = 0;
    k = 0;
    slot_mask_q = m;
    for (int i = 0; i < NSLOT; i++) begin
      band_lo_q[i]  = '0;
      band_opt_q[i] = '0;
      band_hi_q[i]  = '0;
      if (m[i]) n++;
    end
    band_div_q = '0;
    if (n != 0) begin
      step       = (255 * 256) / n;
      band_div_q = BND_W'(step - 256);
      for (int i = 0; i < NSLOT; i++) begin
        if (m[i]) begin
          lo            = k * step;
          op            = (k + 1) * step - 256;
          hi            = 2 * op - lo;
          band_lo_q[i]  = BND_W'(lo);
          band_opt_q[i] = BND_W'(op);
          band_hi_q[i]  = BND_W'(hi);
          k++;
        end
      end
    end
  endfunction

  // Weight each occupied slot by its triangle, sum exactly, divide, saturate.
  function automatic logic [CH*CH_W-1:0] blend_pixel(input pixel_req_t px);
    logic [63:0]        acc [CH];
    logic [63:0]        v;
    logic [BND_W-1:0]   h;
    logic [BND_W-1:0]   num;
    logic [CH*CH_W-1:0] pix;
    h   = BND_W'(px.height);
    pix = '0;
    for (int c = 0; c < CH; c++) acc[c] = '0;
    for (int i = 0; i < NSLOT; i++) begin
      // skip empty slots and heights outside this band
      if (band_div_q != 0 && slot_mask_q[i] && h >= band_lo_q[i] && h <= band_hi_q[i]) begin
        num = (h < band_opt_q[i]) ? h - band_lo_q[i] : band_hi_q[i] - h;
        // channel 0 is red, held in the top byte of the texel
        for (int c = 0; c < CH; c++)
          acc[c] += 64'(px.color[i][(CH-1-c)*CH_W +: CH_W]) * 64'(num);
      end
    end
    for (int c = 0; c < CH; c++) begin
      v = (band_div_q != 0) ? acc[c] / 64'(band_div_q) : 64'd0;
      if (v > 64'd255) v = 64'd255;
      pix[c*CH_W +: CH_W] = v[CH_W-1:0];
    end
    return pix;
  endfunction

  // Track register writes at the same edge the block takes them.
  always @(posedge clk) begin
    if (!rst_n) begin
      load_bands('0);
    end else if (cfg_wen) begin
      load_bands(cfg_wdata);
    end
  end

  // --------------------------------------------------------------------------
  // Request side: pending queue, driver, acceptance tracking.
  // --------------------------------------------------------------------------
  pixel_req_t         pending_px_q [$];
  logic [CH*CH_W-1:0] blended_exp_q [$];
  int unsigned        px_queued   = 0;
  int unsigned        px_accepted = 0;
  int unsigned        send_idle   = 0;
  bit                 calm        = 1'b0;  // no random idling in the last phase

  // Advance to the next request once the current one is taken or none is up.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (send_idle > 0) begin
        send_idle = send_idle - 1;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        send_idle = $urandom_range(1, 12) - 1;
        in_tvalid <= 1'b0;
      end else if (pending_px_q.size() > 0) begin
        in_tdata  <= pending_px_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict the pixel for every accepted request.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      blended_exp_q.push_back(blend_pixel(in_tdata));
      px_accepted = px_accepted + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready generator with random stalls and one long hold-off.
  // --------------------------------------------------------------------------
  int unsigned recv_stall = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && !calm && pending_px_q.size() > 40) begin
      // hold off long enough for the result queue to fill and stall requests
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall = recv_stall - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      recv_stall = $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest prediction, channel by channel.
  int unsigned        errors = 0;
  logic [CH*CH_W-1:0] want_px;
  string              chan_name [CH] = '{"red", "green", "blue"};

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (blended_exp_q.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, actual %h", $time, out_tdata);
        errors = errors + 1;
      end else begin
        want_px = blended_exp_q.pop_front();
        for (int c = 0; c < CH; c++) begin
          if (out_tdata[c*CH_W +: CH_W] !== want_px[c*CH_W +: CH_W]) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, chan_name[c],
                     want_px[c*CH_W +: CH_W], out_tdata[c*CH_W +: CH_W]);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // Drop the run if no handshake of any kind happens for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("height_band_texture_blend test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic pixel_req_t make_px(input logic [H_W-1:0] h, input logic [COL_W-1:0] c0,
                                         input logic [COL_W-1:0] c1, input logic [COL_W-1:0] c2,
                                         input logic [COL_W-1:0] c3);
    pixel_req_t px;
    px.height   = h;
    px.color[0] = c0;
    px.color[1] = c1;
    px.color[2] = c2;
    px.color[3] = c3;
    return px;
  endfunction

  // Random texels; heights either anywhere or close to a band bound.
  function automatic pixel_req_t rand_px();
    pixel_req_t px;
    int         h;
    int unsigned slot;
    for (int i = 0; i < NSLOT; i++) begin
      case ($urandom_range(0, 7))
        0:       px.color[i] = '0;
        1:       px.color[i] = '1;
        default: px.color[i] = COL_W'($urandom);
      endcase
    end
    if (slot_mask_q == 0 || $urandom_range(0, 1) == 0) begin
      px.height = H_W'($urandom);
    end else begin
      slot = $urandom_range(0, NSLOT - 1);
      case ($urandom_range(0, 2))
        0:       h = int'(band_lo_q[slot]);
        1:       h = int'(band_opt_q[slot]);
        default: h = int'(band_hi_q[slot]);
      endcase
      h = h + int'($urandom_range(0, 8)) - 4;
      if (h < 0) h = 0;
      if (h > 65535) h = 65535;
      px.height = H_W'(h);
    end
    return px;
  endfunction

  task automatic push_px(input pixel_req_t px);
    pending_px_q.push_back(px);
    px_queued = px_queued + 1;
  endtask

  // Wait until every queued request has come back, then let the pipe drain.
  task automatic settle();
    while (px_accepted < px_queued || blended_exp_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write the mask, then wait so the band model has picked it up.
  task automatic write_mask(input logic [NSLOT-1:0] m);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  logic [NSLOT-1:0] phase_mask [8] = '{4'hF, 4'h0, 4'h1, 4'h8, 4'h6, 4'hB, 4'h3, 4'hF};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // mask still at reset: nothing occupied, every pixel black
    push_px(make_px(16'h0000, '1, '1, '1, '1));
    push_px(make_px(16'hFFFF, '1, '1, '1, '1));
    push_px(make_px(16'h8000, 24'h123456, 24'hABCDEF, 24'h00FF00, 24'hFF00FF));
    settle();

    // all four slots: band peaks, band edges, band overlap, height extremes
    write_mask(4'hF);
    push_px(make_px(16'h0000, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF));
    push_px(make_px(16'd16064, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF));
    push_px(make_px(16'd16320, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF));
    push_px(make_px(16'd20000, '1, '1, '1, '1));
    push_px(make_px(16'd32128, 24'h804020, 24'h102040, 24'hFFFFFF, 24'h000000));
    push_px(make_px(16'd65024, 24'h000000, 24'h000000, 24'h7F7F7F, 24'hFFFFFF));
    push_px(make_px(16'hFFFF, '1, '1, '1, '1));
    push_px(make_px(16'h00FF, '1, '0, '0, '0));
    settle();

    // slots 0 and 2 only: texels of the empty slots must not leak in
    write_mask(4'h5);
    push_px(make_px(16'd16000, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF));
    push_px(make_px(16'd48000, 24'h000000, 24'hFFFFFF, 24'hA5A5A5, 24'hFFFFFF));
    push_px(make_px(16'd32640, 24'h5A5A5A, 24'hFFFFFF, 24'hA5A5A5, 24'hFFFFFF));
    settle();

    // single slot: one wide band, peak and top of the height range
    write_mask(4'h1);
    push_px(make_px(16'd65024, '1, '0, '0, '0));
    push_px(make_px(16'hFFFF, '1, '0, '0, '0));
    push_px(make_px(16'd32512, 24'h808080, '1, '1, '1));
    settle();

    write_mask(4'h8);
    push_px(make_px(16'd40000, '0, '0, '0, 24'hC0FFEE));
    push_px(make_px(16'h0000, '1, '1, '1, '1));
    settle();

    // random phases, one mask each; the last runs without idling
    for (int p = 0; p < 8; p++) begin
      if (p == 4) phase_mask[p] = NSLOT'($urandom);
      if (p == 7) calm = 1'b1;
      write_mask(phase_mask[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) push_px(rand_px());
      settle();
    end

    if (errors == 0) begin
      $display("height_band_texture_blend test passed");
    end else begin
      $display("height_band_texture_blend test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/hbtb_pkg.sv
rtl/hbtb_bands.sv
rtl/hbtb_lane.sv
rtl/hbtb_merge.sv
rtl/hbtb_div.sv
rtl/height_band_texture_blend.sv
test/tb_height_band_texture_blend.sv
